// ===== src/spijq_pkg.sv =====
package spijq_pkg;

	localparam int ADDR_W  = 32;
	localparam int CTX_W   = 32;
	localparam int LEN_W   = 12;
	localparam int BYTE_W  = 8;
	localparam int FC_W    = 13;
	localparam int ERR_W   = 16;
	localparam int KIND_W  = 2;
	localparam int STAT_W  = 2;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_FRAME = 1'b1;

	localparam logic [KIND_W-1:0] KIND_SEND      = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STORE     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ACTIVATED = 2'd2;
	localparam logic [KIND_W-1:0] KIND_FINISHED  = 2'd3;

	localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STAT_W-1:0] ST_BUS_ERR  = 2'd1;
	localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [CTX_W-1:0]  ctx;
		logic [ADDR_W-1:0] tx_addr;
		logic [ADDR_W-1:0] rx_addr;
		logic [LEN_W-1:0]  tx_len;
		logic [LEN_W-1:0]  rx_len;
	} desc_t;

	localparam int DESC_W = $bits(desc_t);

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CTX_W-1:0]  ctx;
		logic [STAT_W-1:0] status;
		logic [ADDR_W-1:0] addr;
		logic              fill;
		logic [BYTE_W-1:0] data;
		logic [LEN_W-1:0]  len;
		logic [ERR_W-1:0]  error_total;
		logic              last;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OVF,
		S_RD,
		S_EVAL,
		S_NEXT,
		S_FIRST
	} state_t;

	typedef enum logic [1:0] {
		OP_START,
		OP_FRAME,
		OP_FAULT
	} op_t;

endpackage

// ===== src/spijq_ram.sv =====
module spijq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/spi_job_queue_sequencer_core.sv =====
// channel | handshake           | payload
// in      | in_valid / in_ready | command, context_req, tx_address, rx_address,
//         |                     | tx_length, rx_length, rx_byte, bus_error
// out     | out_valid/out_ready | kind, job_context, status, address, use_fill,
//         |                     | data, length, error_total, last
// Add request: queued, or an overflow result if full; into an empty ring it also
// activates the job (descriptor RAM read, then activated and first send). Frame
// request: RAM read; a bus-error finish on a bus error; ignored on an empty ring.
// Finishing with a queued follower re-reads the new head. One request at a time;
// the output register holds results and the sequencer waits while out_ready is low.
// Descriptors are undefined until written, so there is no clearing pass after reset.
module spi_job_queue_sequencer_core #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           command,
	input  logic [spijq_pkg::CTX_W-1:0]    context_req,
	input  logic [spijq_pkg::ADDR_W-1:0]   tx_address,
	input  logic [spijq_pkg::ADDR_W-1:0]   rx_address,
	input  logic [spijq_pkg::LEN_W-1:0]    tx_length,
	input  logic [spijq_pkg::LEN_W-1:0]    rx_length,
	input  logic [spijq_pkg::BYTE_W-1:0]   rx_byte,
	input  logic                           bus_error,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [spijq_pkg::KIND_W-1:0]   kind,
	output logic [spijq_pkg::CTX_W-1:0]    job_context,
	output logic [spijq_pkg::STAT_W-1:0]   status,
	output logic [spijq_pkg::ADDR_W-1:0]   address,
	output logic                           use_fill,
	output logic [spijq_pkg::BYTE_W-1:0]   data,
	output logic [spijq_pkg::LEN_W-1:0]    length,
	output logic [spijq_pkg::ERR_W-1:0]    error_total,
	output logic                           last
);

	import spijq_pkg::*;

	localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int PCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W  = PCNT_W + 1;

	state_t             state_q, state_d;
	op_t                op_q, op_d;
	logic [IDX_W-1:0]   head_q, head_d, head_next, tail;
	logic [PCNT_W-1:0]  pending_q, pending_d;
	logic [FC_W-1:0]    frame_q, frame_d;
	logic [ERR_W-1:0]   error_q, error_d;
	logic [CTX_W-1:0]   ctx_q;
	logic [BYTE_W-1:0]  rxbyte_q;
	logic [SUM_W-1:0]   tail_sum;
	logic               full, accept, out_free;
	logic               wr_en, rd_en, em_valid;
	desc_t              wr_desc, desc;
	res_t               em, res_q;
	logic               out_valid_q;
	logic [FC_W-1:0]    span, rx_off;
	logic               store_hit;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign full     = (pending_q == PCNT_W'(QUEUE_DEPTH));

	assign tail_sum  = SUM_W'(head_q) + SUM_W'(pending_q);
	assign tail      = (tail_sum >= SUM_W'(QUEUE_DEPTH))
		? IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);
	assign head_next = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : IDX_W'(head_q + 1'b1);

	always_comb begin
		wr_desc.ctx     = context_req;
		wr_desc.tx_addr = tx_address;
		wr_desc.rx_addr = rx_address;
		wr_desc.tx_len  = tx_length;
		wr_desc.rx_len  = rx_length;
	end

	spijq_ram #(
		.WIDTH(DESC_W),
		.DEPTH(QUEUE_DEPTH)
	) u_desc_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tail),
		.wr_data (wr_desc),
		.rd_en   (rd_en),
		.rd_addr (head_q),
		.rd_data (desc)
	);

	assign span      = FC_W'(desc.tx_len) + FC_W'(desc.rx_len);
	assign rx_off    = frame_q - FC_W'(desc.tx_len);
	assign store_hit = (frame_q >= FC_W'(desc.tx_len)) && (rx_off < FC_W'(desc.rx_len));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= OP_START;
			head_q    <= '0;
			pending_q <= '0;
			frame_q   <= '0;
			error_q   <= '0;
		end else begin
			state_q   <= state_d;
			op_q      <= op_d;
			head_q    <= head_d;
			pending_q <= pending_d;
			frame_q   <= frame_d;
			error_q   <= error_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctx_q    <= context_req;
			rxbyte_q <= rx_byte;
		end
	end

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		head_d    = head_q;
		pending_d = pending_q;
		frame_d   = frame_q;
		error_d   = error_q;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		em_valid  = 1'b0;
		em        = '0;
		em.error_total = error_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (command == CMD_ADD) begin
						if (full) begin
							error_d = error_q + ERR_W'(1);
							state_d = S_OVF;
						end else begin
							wr_en     = 1'b1;
							pending_d = pending_q + PCNT_W'(1);
							if (pending_q == '0) begin
								op_d    = OP_START;
								state_d = S_RD;
							end
						end
					end else if (pending_q != '0) begin
						if (bus_error) begin
							error_d = error_q + ERR_W'(1);
							op_d    = OP_FAULT;
						end else begin
							op_d    = OP_FRAME;
						end
						state_d = S_RD;
					end
				end
			end
			S_OVF: begin
				em_valid  = 1'b1;
				em.kind   = KIND_FINISHED;
				em.ctx    = ctx_q;
				em.status = ST_OVERFLOW;
				em.last   = 1'b1;
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_RD: begin
				rd_en   = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				case (op_q)
					OP_START: begin
						em_valid = 1'b1;
						em.kind  = KIND_ACTIVATED;
						em.ctx   = desc.ctx;
						if (out_free) begin
							frame_d = '0;
							state_d = S_FIRST;
						end
					end
					OP_FAULT: begin
						em_valid  = 1'b1;
						em.kind   = KIND_FINISHED;
						em.ctx    = desc.ctx;
						em.status = ST_BUS_ERR;
						em.last   = 1'b1;
						if (out_free) begin
							state_d = S_IDLE;
						end
					end
					default: begin
						if (store_hit) begin
							em_valid = 1'b1;
							em.kind  = KIND_STORE;
							em.ctx   = desc.ctx;
							em.addr  = desc.rx_addr + ADDR_W'(rx_off);
							em.data  = rxbyte_q;
						end
						if (!store_hit || out_free) begin
							frame_d = frame_q + FC_W'(1);
							state_d = S_NEXT;
						end
					end
				endcase
			end
			S_NEXT: begin
				em_valid = 1'b1;
				em.ctx   = desc.ctx;
				if (frame_q < span) begin
					em.kind = KIND_SEND;
					em.last = 1'b1;
					if (frame_q < FC_W'(desc.tx_len)) begin
						em.addr = desc.tx_addr + ADDR_W'(frame_q);
					end else begin
						em.fill = 1'b1;
					end
					if (out_free) begin
						state_d = S_IDLE;
					end
				end else begin
					em.kind = KIND_FINISHED;
					em.addr = desc.rx_addr;
					em.len  = desc.rx_len;
					em.last = (pending_q == PCNT_W'(1));
					if (out_free) begin
						pending_d = pending_q - PCNT_W'(1);
						if (pending_q != PCNT_W'(1)) begin
							head_d  = head_next;
							op_d    = OP_START;
							state_d = S_RD;
						end else begin
							state_d = S_IDLE;
						end
					end
				end
			end
			S_FIRST: begin
				em_valid = 1'b1;
				em.kind  = KIND_SEND;
				em.ctx   = desc.ctx;
				em.last  = 1'b1;
				if (desc.tx_len != '0) begin
					em.addr = desc.tx_addr;
				end else begin
					em.fill = 1'b1;
				end
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= em_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && em_valid) begin
			res_q <= em;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = res_q.kind;
	assign job_context = res_q.ctx;
	assign status      = res_q.status;
	assign address     = res_q.addr;
	assign use_fill    = res_q.fill;
	assign data        = res_q.data;
	assign length      = res_q.len;
	assign error_total = res_q.error_total;
	assign last        = res_q.last;

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= PCNT_W'(QUEUE_DEPTH))
		else $error("pending count beyond ring depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		SUM_W'(head_q) < SUM_W'(QUEUE_DEPTH))
		else $error("head index outside ring");

	a_fault_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && command == CMD_FRAME && bus_error && pending_q != '0
		|=> error_q == $past(error_q) + ERR_W'(1))
		else $error("bus error not counted");

	a_act_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.kind == KIND_ACTIVATED && res_q.last))
		else $error("activation marked as final result");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full && accept)
		else $error("descriptor write outside an accepted add request");

endmodule

// ===== bench/tb_spi_job_queue_sequencer_core.sv =====
module tb_spi_job_queue_sequencer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import spijq_pkg::*;

	localparam int DEPTH = 8;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                command;
	logic [CTX_W-1:0]    context_req;
	logic [ADDR_W-1:0]   tx_address;
	logic [ADDR_W-1:0]   rx_address;
	logic [LEN_W-1:0]    tx_length;
	logic [LEN_W-1:0]    rx_length;
	logic [BYTE_W-1:0]   rx_byte;
	logic                bus_error;
	logic                out_valid;
	logic                out_ready;
	logic [KIND_W-1:0]   kind;
	logic [CTX_W-1:0]    job_context;
	logic [STAT_W-1:0]   status;
	logic [ADDR_W-1:0]   address;
	logic                use_fill;
	logic [BYTE_W-1:0]   data;
	logic [LEN_W-1:0]    length;
	logic [ERR_W-1:0]    error_total;
	logic                last;

	spi_job_queue_sequencer_core #(
		.QUEUE_DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.context_req(context_req),
		.tx_address(tx_address),
		.rx_address(rx_address),
		.tx_length(tx_length),
		.rx_length(rx_length),
		.rx_byte(rx_byte),
		.bus_error(bus_error),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.job_context(job_context),
		.status(status),
		.address(address),
		.use_fill(use_fill),
		.data(data),
		.length(length),
		.error_total(error_total),
		.last(last)
	);

	// job ring as the sequencer should hold it
	desc_t            ring [DEPTH];
	int unsigned      ring_head;
	int unsigned      ring_count;
	int unsigned      frames_done;
	logic [ERR_W-1:0] error_tally;
	res_t             due_results [$];

	bit quiet;
	int stall_left;
	int hold_left;
	int fail_count;
	int n_requests;
	int n_results;
	int n_finished;
	int n_bus_err;
	int n_overflow;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void add_due(logic [KIND_W-1:0] k, logic [CTX_W-1:0] c,
			logic [STAT_W-1:0] s, logic [ADDR_W-1:0] a, logic f,
			logic [BYTE_W-1:0] d, logic [LEN_W-1:0] l);
		res_t r;
		r.kind        = k;
		r.ctx         = c;
		r.status      = s;
		r.addr        = a;
		r.fill        = f;
		r.data        = d;
		r.len         = l;
		r.error_total = error_tally;
		r.last        = 1'b0;
		due_results.push_back(r);
	endfunction

	function automatic void activate_head();
		desc_t d;
		d = ring[ring_head];
		add_due(KIND_ACTIVATED, d.ctx, ST_DONE, '0, 1'b0, '0, '0);
		frames_done = 0;
		if (d.tx_len != 0)
			add_due(KIND_SEND, d.ctx, ST_DONE, d.tx_addr, 1'b0, '0, '0);
		else
			add_due(KIND_SEND, d.ctx, ST_DONE, '0, 1'b1, '0, '0);
	endfunction

	function automatic void sequence_request(logic cmd, logic [CTX_W-1:0] ctx,
			logic [ADDR_W-1:0] txa, logic [ADDR_W-1:0] rxa, logic [LEN_W-1:0] txl,
			logic [LEN_W-1:0] rxl, logic [BYTE_W-1:0] rxb, logic berr);
		int unsigned n0;
		int unsigned fc;
		int unsigned txn;
		int unsigned rxn;
		desc_t d;
		res_t r;
		n0 = due_results.size();
		if (cmd == CMD_ADD) begin
			if (ring_count >= DEPTH) begin
				error_tally++;
				add_due(KIND_FINISHED, ctx, ST_OVERFLOW, '0, 1'b0, '0, '0);
			end else begin
				d.ctx     = ctx;
				d.tx_addr = txa;
				d.rx_addr = rxa;
				d.tx_len  = txl;
				d.rx_len  = rxl;
				ring[(ring_head + ring_count) % DEPTH] = d;
				ring_count++;
				if (ring_count == 1)
					activate_head();
			end
		end else if (ring_count != 0) begin
			d = ring[ring_head];
			if (berr) begin
				error_tally++;
				add_due(KIND_FINISHED, d.ctx, ST_BUS_ERR, '0, 1'b0, '0, '0);
			end else begin
				fc  = frames_done;
				txn = d.tx_len;
				rxn = d.rx_len;
				if (fc >= txn && fc - txn < rxn)
					add_due(KIND_STORE, d.ctx, ST_DONE, d.rx_addr + ADDR_W'(fc - txn),
						1'b0, rxb, '0);
				fc++;
				frames_done = fc;
				if (fc < txn + rxn) begin
					if (fc < txn)
						add_due(KIND_SEND, d.ctx, ST_DONE, d.tx_addr + ADDR_W'(fc),
							1'b0, '0, '0);
					else
						add_due(KIND_SEND, d.ctx, ST_DONE, '0, 1'b1, '0, '0);
				end else begin
					add_due(KIND_FINISHED, d.ctx, ST_DONE, d.rx_addr, 1'b0, '0, d.rx_len);
					ring_count--;
					if (ring_count != 0) begin
						ring_head = (ring_head + 1) % DEPTH;
						activate_head();
					end
				end
			end
		end
		if (due_results.size() > n0) begin
			r = due_results.pop_back();
			r.last = 1'b1;
			due_results.push_back(r);
		end
	endfunction

	function automatic string show(res_t r);
		return $sformatf("kind=%0d ctx=%h st=%0d addr=%h fill=%b data=%h len=%0d err=%0d last=%b",
			r.kind, r.ctx, r.status, r.addr, r.fill, r.data, r.len, r.error_total, r.last);
	endfunction

	task automatic send_request(input logic cmd, input logic [CTX_W-1:0] ctx,
			input logic [ADDR_W-1:0] txa, input logic [ADDR_W-1:0] rxa,
			input logic [LEN_W-1:0] txl, input logic [LEN_W-1:0] rxl,
			input logic [BYTE_W-1:0] rxb, input logic berr);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 19);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command     <= cmd;
		context_req <= ctx;
		tx_address  <= txa;
		rx_address  <= rxa;
		tx_length   <= txl;
		rx_length   <= rxl;
		rx_byte     <= rxb;
		bus_error   <= berr;
		in_valid    <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_requests++;
		sequence_request(cmd, ctx, txa, rxa, txl, rxl, rxb, berr);
	endtask

	task automatic add_job(input logic [CTX_W-1:0] ctx, input logic [ADDR_W-1:0] txa,
			input logic [ADDR_W-1:0] rxa, input logic [LEN_W-1:0] txl,
			input logic [LEN_W-1:0] rxl);
		send_request(CMD_ADD, ctx, txa, rxa, txl, rxl, BYTE_W'($urandom), 1'($urandom));
	endtask

	task automatic frame_done(input logic [BYTE_W-1:0] rxb, input logic berr);
		send_request(CMD_FRAME, $urandom, $urandom, $urandom, LEN_W'($urandom),
			LEN_W'($urandom), rxb, berr);
	endtask

	task automatic drain_ring();
		while (ring_count != 0)
			frame_done(BYTE_W'($urandom), 1'b0);
	endtask

	task automatic test_idle_frames();
		frame_done(8'h00, 1'b0);
		frame_done(8'hFF, 1'b1);
	endtask

	task automatic test_empty_job();
		add_job(32'h0000_0000, 32'h0000_0000, 32'h1234_5678, 12'd0, 12'd0);
		frame_done(8'hA5, 1'b0);
	endtask

	task automatic test_address_wrap();
		add_job(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'd2, 12'd2);
		drain_ring();
	endtask

	task automatic test_bus_error();
		add_job($urandom, $urandom, $urandom, 12'd1, 12'd2);
		frame_done(8'h3C, 1'b1);
		frame_done(8'hC3, 1'b0);
		frame_done(8'h5A, 1'b1);
		drain_ring();
	endtask

	// receiver held off at first, then the ring fills and overflows
	task automatic test_full_ring_backpressure();
		int i;
		quiet = 1'b1;
		hold_left = 200;
		for (i = 0; i < DEPTH + 2; i++) begin
			if (i < DEPTH)
				add_job($urandom, $urandom, $urandom, LEN_W'(i % 3), LEN_W'(i % 2));
			else
				add_job($urandom, $urandom, $urandom, LEN_W'($urandom), LEN_W'($urandom));
		end
		quiet = 1'b0;
		drain_ring();
	endtask

	task automatic test_longest_job();
		quiet = 1'b1;
		add_job($urandom, 32'hFFFF_FFF8, 32'hFFFF_FFFA, 12'd12, 12'd12);
		drain_ring();
		quiet = 1'b0;
	endtask

	task automatic test_random_traffic();
		int sent;
		bit adding;
		logic [LEN_W-1:0] txl;
		logic [LEN_W-1:0] rxl;
		sent = 0;
		while (sent < 110) begin
			quiet = ((sent / 25) % 4) == 3;
			if (ring_count == 0)
				adding = $urandom_range(0, 9) != 0;
			else
				adding = $urandom_range(0, 3) == 0;
			if (adding) begin
				if (ring_count >= DEPTH) begin
					txl = LEN_W'($urandom);
					rxl = LEN_W'($urandom);
				end else if ($urandom_range(0, 9) < 7) begin
					txl = LEN_W'($urandom_range(0, 4));
					rxl = LEN_W'($urandom_range(0, 4));
				end else begin
					txl = LEN_W'($urandom_range(0, 12));
					rxl = LEN_W'($urandom_range(0, 12));
				end
				add_job($urandom, $urandom, $urandom, txl, rxl);
				sent++;
			end else begin
				if (ring_count != 0)
					sent++;
				frame_done(BYTE_W'($urandom), $urandom_range(0, 9) == 0);
			end
		end
		quiet = 1'b0;
	endtask

	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left--;
	end

	initial begin : result_sink
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		res_t got;
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			got.kind        = kind;
			got.ctx         = job_context;
			got.status      = status;
			got.addr        = address;
			got.fill        = use_fill;
			got.data        = data;
			got.len         = length;
			got.error_total = error_total;
			got.last        = last;
			n_results++;
			stall_left = quiet ? 0 : $urandom_range(0, 19);
			if (got.kind == KIND_FINISHED) begin
				if (got.status == ST_BUS_ERR)
					n_bus_err++;
				else if (got.status == ST_OVERFLOW)
					n_overflow++;
				else
					n_finished++;
			end
			if (due_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: %s", show(got));
			end else begin
				want = due_results.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("mismatch at %0t", $realtime);
						$display("  expected %s", show(want));
						$display("  actual   %s", show(got));
					end
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		command     = CMD_ADD;
		context_req = '0;
		tx_address  = '0;
		rx_address  = '0;
		tx_length   = '0;
		rx_length   = '0;
		rx_byte     = '0;
		bus_error   = 1'b0;
		ring_head   = 0;
		ring_count  = 0;
		frames_done = 0;
		error_tally = '0;
		quiet       = 1'b0;
		stall_left  = 0;
		hold_left   = 0;
		fail_count  = 0;
		n_requests  = 0;
		n_results   = 0;
		n_finished  = 0;
		n_bus_err   = 0;
		n_overflow  = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_frames();
		test_empty_job();
		test_address_wrap();
		test_bus_error();
		test_full_ring_backpressure();
		test_longest_job();
		test_random_traffic();

		@(negedge clk);
		in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("%0d requests sent, %0d results checked", n_requests, n_results);
		$display("%0d jobs completed, %0d bus errors and %0d ring overflows reported",
			n_finished, n_bus_err, n_overflow);
		if (fail_count == 0 && due_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
